### hdl/poisson_disk_candidate_check_defines.svh
// ----------------------------------------------------------------------------
// poisson disk candidate check assertion macros
// shared property shapes for the engine checks
// ----------------------------------------------------------------------------
`ifndef POISSON_DISK_CANDIDATE_CHECK_DEFINES_SVH
`define POISSON_DISK_CANDIDATE_CHECK_DEFINES_SVH

// same-cycle implication
`define PDCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pdcc assertion failed");

// next-cycle implication
`define PDCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pdcc assertion failed");

`endif

### hdl/pdcc_pkg.sv
// ----------------------------------------------------------------------------
// pdcc_pkg
// types and constants of the poisson disk candidate check engine
// ----------------------------------------------------------------------------
package pdcc_pkg;

    localparam int MAX_GRID_COLS = 64;
    localparam int MAX_GRID_ROWS = 64;
    localparam int MAX_POINTS    = 4096;
    localparam int SEARCH_REACH  = 2;
    localparam int GRID_DEPTH    = MAX_GRID_COLS * MAX_GRID_ROWS;
    localparam int GRID_AW       = $clog2(GRID_DEPTH);
    localparam int PT_AW         = $clog2(MAX_POINTS);
    localparam int COORD_W       = 24;
    localparam int NUM_W         = 13;
    localparam int CELL_W        = 6;
    localparam int DIM_W         = 7;
    localparam int SQ_W          = 48;

    localparam logic [2:0] STATUS_ACCEPT  = 3'd0;
    localparam logic [2:0] STATUS_OUTSIDE = 3'd1;
    localparam logic [2:0] STATUS_CLOSE   = 3'd2;
    localparam logic [2:0] STATUS_FULL    = 3'd3;
    localparam logic [2:0] STATUS_CLEARED = 3'd4;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CELL   = 3'd2;
    localparam logic [2:0] REG_RADSQ  = 3'd3;
    localparam logic [2:0] REG_COLS   = 3'd4;
    localparam logic [2:0] REG_ROWS   = 3'd5;

    typedef struct packed {
        logic                 kind;
        logic [COORD_W-1:0]   cand_x;
        logic [COORD_W-1:0]   cand_y;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           status;
        logic [NUM_W-1:0]     point_number;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIVX,
        ST_DIVY,
        ST_SCAN_ADDR,
        ST_SCAN_GRID,
        ST_SCAN_PT,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

### hdl/pdcc_ram.sv
// ----------------------------------------------------------------------------
// pdcc_ram
// generic one write port, one read port ram with registered read data
// ----------------------------------------------------------------------------
module pdcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/poisson_disk_candidate_check.sv
// ----------------------------------------------------------------------------
// poisson disk candidate check
// grid based accept and insert engine for poisson disk sampling
// ----------------------------------------------------------------------------
// One item is worked at a time. A clear item sweeps the 4096-entry occupancy
// grid one entry per cycle; the same sweep runs after reset, during which no
// item is taken. A candidate outside the region goes straight to its result.
// Any other candidate runs two 24-step restoring divisions on one shared
// divider, then scans up to 25 grid cells: an empty cell passes an address
// and a grid read state, an occupied one also a point read, two squaring
// states through a single shared 24x24 multiplier, and a compare.
// The next item may be taken while a result beat still waits at the output.
// ----------------------------------------------------------------------------
`include "poisson_disk_candidate_check_defines.svh"

module poisson_disk_candidate_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pdcc_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pdcc_pkg::t_out_item   o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    localparam int CW = pdcc_pkg::COORD_W;
    localparam int GW = pdcc_pkg::GRID_AW;
    localparam int PW = pdcc_pkg::PT_AW;
    localparam int NW = pdcc_pkg::NUM_W;
    localparam int EW = pdcc_pkg::CELL_W;
    localparam int SW = pdcc_pkg::SQ_W;
    localparam logic [EW:0] REACH = (EW+1)'(pdcc_pkg::SEARCH_REACH);

    // configuration
    logic [CW-1:0] r_width, r_height, r_cell;
    logic [SW-1:0] r_radsq;
    logic [pdcc_pkg::DIM_W-1:0] r_cols, r_rows;
    logic [2:0] cfg_idx;

    assign cfg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CW'(16384);
            r_height <= CW'(16384);
            r_cell   <= CW'(256);
            r_radsq  <= SW'(131072);
            r_cols   <= 7'd64;
            r_rows   <= 7'd64;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                pdcc_pkg::REG_WIDTH:  r_width  <= pwdata[CW-1:0];
                pdcc_pkg::REG_HEIGHT: r_height <= pwdata[CW-1:0];
                pdcc_pkg::REG_CELL:   r_cell   <= pwdata[CW-1:0];
                pdcc_pkg::REG_RADSQ:  r_radsq  <= pwdata[SW-1:0];
                pdcc_pkg::REG_COLS:   r_cols   <= pwdata[6:0];
                pdcc_pkg::REG_ROWS:   r_rows   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            pdcc_pkg::REG_WIDTH:  prdata = 64'(r_width);
            pdcc_pkg::REG_HEIGHT: prdata = 64'(r_height);
            pdcc_pkg::REG_CELL:   prdata = 64'(r_cell);
            pdcc_pkg::REG_RADSQ:  prdata = 64'(r_radsq);
            pdcc_pkg::REG_COLS:   prdata = 64'(r_cols);
            pdcc_pkg::REG_ROWS:   prdata = 64'(r_rows);
            default:              prdata = 64'd0;
        endcase
    end

    // effective geometry
    logic [CW-1:0] cs;
    logic [pdcc_pkg::DIM_W-1:0] cols_eff, rows_eff;
    logic [EW-1:0] colm, rowm;

    assign cs = (r_cell == '0) ? CW'(1) : r_cell;

    always_comb begin
        cols_eff = r_cols;
        if (r_cols == '0) begin
            cols_eff = 7'd1;
        end else if (r_cols > 7'(pdcc_pkg::MAX_GRID_COLS)) begin
            cols_eff = 7'(pdcc_pkg::MAX_GRID_COLS);
        end
        rows_eff = r_rows;
        if (r_rows == '0) begin
            rows_eff = 7'd1;
        end else if (r_rows > 7'(pdcc_pkg::MAX_GRID_ROWS)) begin
            rows_eff = 7'(pdcc_pkg::MAX_GRID_ROWS);
        end
    end

    assign colm = EW'(cols_eff - 7'd1);
    assign rowm = EW'(rows_eff - 7'd1);

    // engine registers
    pdcc_pkg::t_state r_state, n_state;
    logic            r_init, n_init;
    logic [CW-1:0]   r_cx, n_cx, r_cy, n_cy;
    logic [CW-1:0]   r_rem, n_rem, r_quo, n_quo;
    logic [4:0]      r_bit, n_bit;
    logic [EW-1:0]   r_gx, n_gx, r_gy, n_gy;
    logic [EW-1:0]   r_x, n_x, r_y, n_y, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic [SW-1:0]   r_pt, n_pt, r_sq, n_sq, r_acc, n_acc;
    logic [GW-1:0]   r_clr, n_clr;
    logic [NW-1:0]   r_count, n_count, r_num, n_num;
    logic [2:0]      r_status, n_status;
    logic            r_out_valid, n_out_valid;
    pdcc_pkg::t_out_item r_out, n_out;

    // shared divider step
    logic [CW:0]   rem_sh;
    logic          q_bit;
    logic [CW-1:0] rem_nx;
    logic [CW-1:0] quo_nx;
    logic [EW-1:0] cell_x, cell_y;

    assign rem_sh = {r_rem, r_quo[CW-1]};
    assign q_bit  = rem_sh >= {1'b0, cs};
    assign rem_nx = q_bit ? CW'(rem_sh - {1'b0, cs}) : rem_sh[CW-1:0];
    assign quo_nx = {r_quo[CW-2:0], q_bit};
    assign cell_x = (quo_nx > CW'(colm)) ? colm : quo_nx[EW-1:0];
    assign cell_y = (quo_nx > CW'(rowm)) ? rowm : quo_nx[EW-1:0];

    // shared squaring multiplier
    logic [CW-1:0] op_a, op_b, diff;
    logic [SW-1:0] prod;

    always_comb begin
        if (r_state == pdcc_pkg::ST_SQX) begin
            op_a = r_cx;
            op_b = r_pt[CW-1:0];
        end else begin
            op_a = r_cy;
            op_b = r_pt[SW-1:CW];
        end
    end

    assign diff = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
    assign prod = diff * diff;

    logic [SW:0] dist_sq;
    assign dist_sq = {1'b0, r_acc} + {1'b0, r_sq};

    // memories
    logic          grid_we;
    logic [GW-1:0] grid_waddr, grid_raddr;
    logic [NW-1:0] grid_wdata, grid_rdata;
    logic          pt_we;
    logic [PW-1:0] pt_raddr;
    logic [SW-1:0] pt_rdata;
    logic [GW-1:0] scan_addr, ins_addr;

    assign scan_addr = GW'({6'd0, r_x} + cols_eff * r_y);
    assign ins_addr  = GW'({6'd0, r_gx} + cols_eff * r_gy);

    pdcc_ram #(
        .WIDTH(NW),
        .DEPTH(pdcc_pkg::GRID_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (grid_waddr),
        .i_wdata (grid_wdata),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    pdcc_ram #(
        .WIDTH(SW),
        .DEPTH(pdcc_pkg::MAX_POINTS)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (r_count[PW-1:0]),
        .i_wdata ({r_cy, r_cx}),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    assign grid_raddr = scan_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdcc_pkg::ST_CLEAR;
            r_init      <= 1'b1;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_bit    <= n_bit;
        r_gx     <= n_gx;
        r_gy     <= n_gy;
        r_x      <= n_x;
        r_y      <= n_y;
        r_y0     <= n_y0;
        r_x1     <= n_x1;
        r_y1     <= n_y1;
        r_pt     <= n_pt;
        r_sq     <= n_sq;
        r_acc    <= n_acc;
        r_num    <= n_num;
        r_status <= n_status;
        r_out    <= n_out;
    end

    logic [EW:0] hi_x, hi_y;
    assign hi_x = {1'b0, r_gx} + REACH;
    assign hi_y = {1'b0, cell_y} + REACH;

    logic [NW-1:0] grid_n;
    assign grid_n = grid_rdata;

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_x         = r_x;
        n_y         = r_y;
        n_y0        = r_y0;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_pt        = r_pt;
        n_sq        = r_sq;
        n_acc       = r_acc;
        n_clr       = r_clr;
        n_count     = r_count;
        n_num       = r_num;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        grid_we     = 1'b0;
        grid_waddr  = r_clr;
        grid_wdata  = '0;
        pt_we       = 1'b0;
        pt_raddr    = PW'(grid_n - NW'(1));

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            pdcc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_cx       = i_in_data.cand_x;
                n_cy       = i_in_data.cand_y;
                n_rem      = '0;
                n_quo      = i_in_data.cand_x;
                n_bit      = '0;
                n_num      = '0;
                n_clr      = '0;
                if (i_in_valid) begin
                    if (i_in_data.kind) begin
                        n_init  = 1'b0;
                        n_state = pdcc_pkg::ST_CLEAR;
                    end else if (i_in_data.cand_x >= r_width
                                 || i_in_data.cand_y >= r_height) begin
                        n_status = pdcc_pkg::STATUS_OUTSIDE;
                        n_state  = pdcc_pkg::ST_DONE;
                    end else begin
                        n_state = pdcc_pkg::ST_DIVX;
                    end
                end
            end
            pdcc_pkg::ST_CLEAR: begin
                grid_we = 1'b1;
                n_clr   = r_clr + GW'(1);
                if (r_clr == GW'(pdcc_pkg::GRID_DEPTH - 1)) begin
                    n_count = '0;
                    if (r_init) begin
                        n_state = pdcc_pkg::ST_IDLE;
                    end else begin
                        n_status = pdcc_pkg::STATUS_CLEARED;
                        n_num    = '0;
                        n_state  = pdcc_pkg::ST_DONE;
                    end
                end
            end
            pdcc_pkg::ST_DIVX: begin
                n_rem = rem_nx;
                n_quo = quo_nx;
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'(CW - 1)) begin
                    n_gx    = cell_x;
                    n_rem   = '0;
                    n_quo   = r_cy;
                    n_bit   = '0;
                    n_state = pdcc_pkg::ST_DIVY;
                end
            end
            pdcc_pkg::ST_DIVY: begin
                n_rem = rem_nx;
                n_quo = quo_nx;
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'(CW - 1)) begin
                    n_gy    = cell_y;
                    n_x     = (r_gx >= EW'(REACH)) ? r_gx - EW'(REACH) : '0;
                    n_y     = (cell_y >= EW'(REACH)) ? cell_y - EW'(REACH) : '0;
                    n_y0    = n_y;
                    n_x1    = (hi_x > {1'b0, colm}) ? colm : hi_x[EW-1:0];
                    n_y1    = (hi_y > {1'b0, rowm}) ? rowm : hi_y[EW-1:0];
                    n_state = pdcc_pkg::ST_SCAN_ADDR;
                end
            end
            pdcc_pkg::ST_SCAN_ADDR: begin
                n_state = pdcc_pkg::ST_SCAN_GRID;
            end
            pdcc_pkg::ST_SCAN_GRID: begin
                if (grid_n != '0 && grid_n <= NW'(pdcc_pkg::MAX_POINTS)) begin
                    n_state = pdcc_pkg::ST_SCAN_PT;
                end else if (r_y != r_y1) begin
                    n_y     = r_y + EW'(1);
                    n_state = pdcc_pkg::ST_SCAN_ADDR;
                end else if (r_x != r_x1) begin
                    n_x     = r_x + EW'(1);
                    n_y     = r_y0;
                    n_state = pdcc_pkg::ST_SCAN_ADDR;
                end else begin
                    n_state = pdcc_pkg::ST_CHECK;
                end
            end
            pdcc_pkg::ST_SCAN_PT: begin
                n_pt    = pt_rdata;
                n_state = pdcc_pkg::ST_SQX;
            end
            pdcc_pkg::ST_SQX: begin
                n_sq    = prod;
                n_state = pdcc_pkg::ST_SQY;
            end
            pdcc_pkg::ST_SQY: begin
                n_acc   = r_sq;
                n_sq    = prod;
                n_state = pdcc_pkg::ST_CMP;
            end
            pdcc_pkg::ST_CMP: begin
                if (dist_sq < {1'b0, r_radsq}) begin
                    n_status = pdcc_pkg::STATUS_CLOSE;
                    n_state  = pdcc_pkg::ST_DONE;
                end else if (r_y != r_y1) begin
                    n_y     = r_y + EW'(1);
                    n_state = pdcc_pkg::ST_SCAN_ADDR;
                end else if (r_x != r_x1) begin
                    n_x     = r_x + EW'(1);
                    n_y     = r_y0;
                    n_state = pdcc_pkg::ST_SCAN_ADDR;
                end else begin
                    n_state = pdcc_pkg::ST_CHECK;
                end
            end
            pdcc_pkg::ST_CHECK: begin
                if (r_count >= NW'(pdcc_pkg::MAX_POINTS)) begin
                    n_status = pdcc_pkg::STATUS_FULL;
                end else begin
                    pt_we      = 1'b1;
                    grid_we    = 1'b1;
                    grid_waddr = ins_addr;
                    grid_wdata = r_count + NW'(1);
                    n_count    = r_count + NW'(1);
                    n_num      = r_count + NW'(1);
                    n_status   = pdcc_pkg::STATUS_ACCEPT;
                end
                n_state = pdcc_pkg::ST_DONE;
            end
            pdcc_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status       = r_status;
                    n_out.point_number = r_num;
                    n_out_valid        = 1'b1;
                    n_state            = pdcc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pdcc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    logic out_not_accept;
    logic insert_now;
    assign out_not_accept = o_out_valid && (o_out_data.status != pdcc_pkg::STATUS_ACCEPT);
    assign insert_now     = (r_state == pdcc_pkg::ST_CHECK) && pt_we;

    `PDCC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= NW'(pdcc_pkg::MAX_POINTS))
    `PDCC_ASSERT_NOW(a_number_only_accept, out_not_accept, o_out_data.point_number == '0)
    `PDCC_ASSERT_NEXT(a_insert_counts, insert_now, r_count == $past(r_count) + NW'(1))

endmodule
